// ----- rtl/core/kwmt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kwmt_pkg
// Shared sizes, codes and types of the keyed waveform match table.
// ----------------------------------------------------------------------------
package kwmt_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned WAVE_WORDS  = 4;
  localparam int unsigned IN_WORDS    = 4;
  localparam int unsigned LANES       = 4;
  localparam int unsigned WORD_W      = 32;

  localparam int unsigned LANE_W = $clog2(LANES);
  localparam int unsigned ROWS   = (TABLE_DEPTH + LANES - 1) / LANES;
  localparam int unsigned ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SLOT_W = ROW_W + LANE_W;
  localparam int unsigned CMP_W  = (SLOT_W > CNT_W) ? SLOT_W : CNT_W;

  typedef logic [WORD_W-1:0]                  word_t;
  typedef logic [WAVE_WORDS-1:0][WORD_W-1:0]  wave_t;
  typedef logic [ROW_W-1:0]                   row_t;
  typedef logic [LANE_W-1:0]                  lane_t;
  typedef logic [CNT_W-1:0]                   cnt_t;
  typedef logic [SLOT_W-1:0]                  slot_t;
  typedef logic [CMP_W-1:0]                   cmp_t;
  typedef logic [5:0]                         slot_out_t;
  typedef logic [6:0]                         cnt_out_t;

  typedef enum logic [1:0] {
    K_APPEND    = 2'd0,
    K_FIND_WAVE = 2'd1,
    K_FIND_ID   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    word_t id;
    wave_t wave;
  } rec_t;

  typedef struct packed {
    logic by_wave;
    rec_t key;
  } query_t;

  typedef struct packed {
    logic valid;
    logic last;
    row_t row;
  } rd_tag_t;

  typedef struct packed {
    logic  valid;
    logic  last;
    logic  found;
    slot_t slot;
  } merge_t;

  // words past the input width are taken as zero
  function automatic wave_t pack_wave(word_t a, word_t b, word_t c, word_t d);
    wave_t r;
    word_t src [IN_WORDS];
    src[0] = a;
    src[1] = b;
    src[2] = c;
    src[3] = d;
    for (int w = 0; w < int'(WAVE_WORDS); w++) begin
      if (w < int'(IN_WORDS)) begin
        r[w] = src[w];
      end else begin
        r[w] = '0;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/kwmt_lane.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kwmt_lane
// One bank of records (every LANES-th slot) with a registered read port and
// the compare of the read record against the current query.
// ----------------------------------------------------------------------------
module kwmt_lane (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire kwmt_pkg::row_t  wr_row_i,
  input  wire kwmt_pkg::rec_t  wr_rec_i,
  input  wire kwmt_pkg::row_t  rd_row_i,
  input  wire kwmt_pkg::query_t query_i,
  output logic                 hit_o
);

  kwmt_pkg::rec_t mem_q [kwmt_pkg::ROWS];
  kwmt_pkg::rec_t rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_row_i] <= wr_rec_i;
    end
    rd_q <= mem_q[rd_row_i];
  end

  assign hit_o = query_i.by_wave ? (rd_q.wave == query_i.key.wave)
                                 : (rd_q.id == query_i.key.id);

endmodule
`default_nettype wire

// ----- rtl/core/kwmt_merge.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kwmt_merge
// Combines the lane hits of one row: drops slots at or past the entry count
// and keeps the lowest lane, which is the earliest slot of the row.
// ----------------------------------------------------------------------------
module kwmt_merge (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic [kwmt_pkg::LANES-1:0]      hit_i,
  input  wire kwmt_pkg::rd_tag_t               tag_i,
  input  wire kwmt_pkg::cnt_t                  count_i,
  output kwmt_pkg::merge_t                     res_o
);

  kwmt_pkg::merge_t res_d;
  kwmt_pkg::merge_t res_q;

  always_comb begin
    res_d       = '0;
    res_d.valid = tag_i.valid;
    res_d.last  = tag_i.last;
    for (int l = int'(kwmt_pkg::LANES) - 1; l >= 0; l--) begin
      if (hit_i[l] &&
          (kwmt_pkg::cmp_t'({tag_i.row, kwmt_pkg::lane_t'(l)}) <
           kwmt_pkg::cmp_t'(count_i))) begin
        res_d.found = 1'b1;
        res_d.slot  = {tag_i.row, kwmt_pkg::lane_t'(l)};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

// ----- rtl/core/keyed_waveform_match_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_waveform_match_table
// Table of identifier plus waveform records with append, lookup by waveform
// and lookup by identifier.
// ----------------------------------------------------------------------------
// One item is taken at a time and gives one result. An append's result goes
// through the pending registers to the output register. A lookup reads four
// records per cycle, one from each lane's bank, row by row, and stops early at
// the first match; an empty table, or an unused kind, goes straight to the
// finish state. A new item is taken as soon as the previous one is finished,
// even while its result still waits in the output register.
module keyed_waveform_match_table (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         kind_i,
  input  wire logic signed [31:0] record_id_i,
  input  wire logic signed [31:0] wave_word_a_i,
  input  wire logic signed [31:0] wave_word_b_i,
  input  wire logic signed [31:0] wave_word_c_i,
  input  wire logic signed [31:0] wave_word_d_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              status_o,
  output logic [5:0]              slot_index_o,
  output logic [6:0]              entry_count_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  state_e                    state_q;
  kwmt_pkg::cnt_t            count_q;
  kwmt_pkg::row_t            row_q;
  kwmt_pkg::row_t            last_row_q;
  logic                      issue_q;
  kwmt_pkg::query_t          query_q;
  kwmt_pkg::rd_tag_t         tag_q;
  kwmt_pkg::rd_tag_t         tag_d;
  kwmt_pkg::rd_tag_t         tag_in;
  kwmt_pkg::status_e         pend_status_q;
  kwmt_pkg::slot_out_t       pend_slot_q;
  kwmt_pkg::cnt_out_t        pend_count_q;
  logic                      out_valid_q;
  kwmt_pkg::status_e         status_q;
  kwmt_pkg::slot_out_t       slot_q;
  kwmt_pkg::cnt_out_t        count_out_q;

  logic                      in_fire;
  logic                      out_free;
  logic                      full;
  logic                      wr_en;
  kwmt_pkg::kind_e           in_kind;
  kwmt_pkg::rec_t            in_rec;
  kwmt_pkg::row_t            wr_row;
  logic [kwmt_pkg::LANES-1:0] lane_we;
  logic [kwmt_pkg::LANES-1:0] lane_hit;
  kwmt_pkg::merge_t          merge;
  logic                      scan_done;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_kind    = kwmt_pkg::kind_e'(kind_i);
  assign full       = (count_q == kwmt_pkg::cnt_t'(kwmt_pkg::TABLE_DEPTH));
  assign in_rec.id  = record_id_i;
  assign in_rec.wave = kwmt_pkg::pack_wave(wave_word_a_i, wave_word_b_i,
                                           wave_word_c_i, wave_word_d_i);
  assign wr_en      = in_fire && (in_kind == kwmt_pkg::K_APPEND) && !full;
  assign wr_row     = kwmt_pkg::row_t'(count_q >> kwmt_pkg::LANE_W);

  always_comb begin
    for (int l = 0; l < int'(kwmt_pkg::LANES); l++) begin
      lane_we[l] = wr_en &&
                   (count_q[kwmt_pkg::LANE_W-1:0] == kwmt_pkg::lane_t'(l));
    end
  end

  // read tag is registered alongside the bank read, so it arrives with the read record
  always_comb begin
    tag_d       = '0;
    tag_d.valid = (state_q == S_SCAN) && issue_q && !scan_done;
    tag_d.last  = (row_q == last_row_q);
    tag_d.row   = row_q;
  end

  always_comb begin
    tag_in       = tag_q;
    tag_in.valid = tag_q.valid && (state_q == S_SCAN);
  end

  assign scan_done = (state_q == S_SCAN) && merge.valid && (merge.found || merge.last);

  for (genvar g = 0; g < int'(kwmt_pkg::LANES); g++) begin : g_lane
    kwmt_lane u_lane (
      .clk_i    (clk_i),
      .we_i     (lane_we[g]),
      .wr_row_i (wr_row),
      .wr_rec_i (in_rec),
      .rd_row_i (row_q),
      .query_i  (query_q),
      .hit_o    (lane_hit[g])
    );
  end

  kwmt_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .hit_i   (lane_hit),
    .tag_i   (tag_in),
    .count_i (count_q),
    .res_o   (merge)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      count_q       <= '0;
      row_q         <= '0;
      last_row_q    <= '0;
      issue_q       <= 1'b0;
      query_q       <= '0;
      tag_q         <= '0;
      pend_status_q <= kwmt_pkg::ST_MISS;
      pend_slot_q   <= '0;
      pend_count_q  <= '0;
      out_valid_q   <= 1'b0;
      status_q      <= kwmt_pkg::ST_MISS;
      slot_q        <= '0;
      count_out_q   <= '0;
    end else begin
      tag_q <= tag_d;
      // in finish a taken result is always replaced by the pending one
      if (out_ready_i && (state_q != S_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            query_q.key     <= in_rec;
            query_q.by_wave <= (in_kind == kwmt_pkg::K_FIND_WAVE);
            unique case (in_kind) inside
              kwmt_pkg::K_APPEND: begin
                state_q <= S_FINISH;
                if (full) begin
                  pend_status_q <= kwmt_pkg::ST_FULL;
                  pend_slot_q   <= '0;
                  pend_count_q  <= kwmt_pkg::cnt_out_t'(count_q);
                end else begin
                  pend_status_q <= kwmt_pkg::ST_OK;
                  pend_slot_q   <= kwmt_pkg::slot_out_t'(count_q);
                  pend_count_q  <= kwmt_pkg::cnt_out_t'(count_q + 1'b1);
                  count_q       <= kwmt_pkg::cnt_t'(count_q + 1'b1);
                end
              end
              kwmt_pkg::K_FIND_WAVE, kwmt_pkg::K_FIND_ID: begin
                pend_status_q <= kwmt_pkg::ST_MISS;
                pend_slot_q   <= '0;
                pend_count_q  <= kwmt_pkg::cnt_out_t'(count_q);
                if (count_q != '0) begin
                  row_q      <= '0;
                  last_row_q <= kwmt_pkg::row_t'((count_q - 1'b1) >> kwmt_pkg::LANE_W);
                  issue_q    <= 1'b1;
                  state_q    <= S_SCAN;
                end else begin
                  state_q <= S_FINISH;
                end
              end
              default: begin
                pend_status_q <= kwmt_pkg::ST_MISS;
                pend_slot_q   <= '0;
                pend_count_q  <= kwmt_pkg::cnt_out_t'(count_q);
                state_q       <= S_FINISH;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (issue_q) begin
            row_q <= kwmt_pkg::row_t'(row_q + 1'b1);
          end
          if (scan_done || (issue_q && (row_q == last_row_q))) begin
            issue_q <= 1'b0;
          end
          if (scan_done) begin
            state_q <= S_FINISH;
            if (merge.found) begin
              pend_status_q <= kwmt_pkg::ST_OK;
              pend_slot_q   <= kwmt_pkg::slot_out_t'(merge.slot);
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            status_q    <= pend_status_q;
            slot_q      <= pend_slot_q;
            count_out_q <= pend_count_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign slot_index_o  = slot_q;
  assign entry_count_o = count_out_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kwmt_pkg::cmp_t'(count_q) <= kwmt_pkg::cmp_t'(kwmt_pkg::TABLE_DEPTH))
    else $error("entry count past table depth");

  a_one_bank_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(lane_we))
    else $error("more than one bank written");

  a_full_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_kind == kwmt_pkg::K_APPEND) && full) |=> (count_q == $past(count_q)))
    else $error("refused append changed the count");

  a_hit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (merge.valid && merge.found && (state_q == S_SCAN)) |->
    (kwmt_pkg::cmp_t'(merge.slot) < kwmt_pkg::cmp_t'(count_q)))
    else $error("match reported past the entry count");

  a_issue_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_q |-> (state_q == S_SCAN))
    else $error("bank reads issued outside a scan");
`endif

endmodule
`default_nettype wire
